// ----- design/owrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_pkg : shared types for the 1-Wire ROM search engine
// Payload structs, decoded operation codes and queue entry layout.
// ----------------------------------------------------------------------------
package owrs_pkg;

	localparam int RomBits = 64;
	localparam int PosBits = 7;
	localparam int IdxBits = 6;
	localparam int QueueDepth = 2;
	localparam int QueuePtrBits = 1;
	localparam int QueueCntBits = 2;

	// raw action codes on the input channel
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_BEGIN = 2'd1;
	localparam logic [1:0] ACT_PAIR = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic       presence;
		logic       id_bit;
		logic       complement_bit;
	} item_t;

	typedef struct packed {
		logic                 send_search_command;
		logic                 write_valid;
		logic                 direction_bit;
		logic                 pass_done;
		logic                 found;
		logic [RomBits-1:0]   address;
		logic                 last_device;
	} result_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_BEGIN,
		OP_PAIR,
		OP_NONE
	} op_e_t;

	// what the two slot bits say about the devices still on the branch
	typedef enum logic [1:0] {
		PAIR_ABORT,     // nobody answered
		PAIR_FORCED,    // all remaining devices agree on this bit
		PAIR_CONFLICT   // both values present
	} pair_e_t;

	typedef struct packed {
		op_e_t   op;
		logic    presence;
		pair_e_t pair;
		logic    id_bit;
	} op_entry_t;

endpackage

// ----- design/owrs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_front : input decode
// Turns each incoming transaction into a decoded operation for the queue.
// ----------------------------------------------------------------------------
module owrs_front (
	input  owrs_pkg::item_t     item,
	input  logic                item_valid,
	input  logic                queue_full,
	output logic                item_stall,
	output logic                push,
	output owrs_pkg::op_entry_t push_entry
);

	assign item_stall = queue_full;
	assign push = item_valid && !queue_full;

	always_comb begin
		push_entry.presence = item.presence;
		push_entry.id_bit = item.id_bit;
		unique case (item.action)
			owrs_pkg::ACT_CLEAR: push_entry.op = owrs_pkg::OP_CLEAR;
			owrs_pkg::ACT_BEGIN: push_entry.op = owrs_pkg::OP_BEGIN;
			owrs_pkg::ACT_PAIR:  push_entry.op = owrs_pkg::OP_PAIR;
			default:             push_entry.op = owrs_pkg::OP_NONE;
		endcase
		priority if (item.id_bit && item.complement_bit) begin
			push_entry.pair = owrs_pkg::PAIR_ABORT;
		end else if (item.id_bit != item.complement_bit) begin
			push_entry.pair = owrs_pkg::PAIR_FORCED;
		end else begin
			push_entry.pair = owrs_pkg::PAIR_CONFLICT;
		end
	end

endmodule

// ----- design/owrs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_queue : two-entry operation queue
// Decouples input decode from the search engine so each side stalls alone.
// ----------------------------------------------------------------------------
module owrs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  owrs_pkg::op_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output owrs_pkg::op_entry_t head
);

	owrs_pkg::op_entry_t                    entry_q [owrs_pkg::QueueDepth];
	logic [owrs_pkg::QueuePtrBits-1:0]      wr_ptr_q;
	logic [owrs_pkg::QueuePtrBits-1:0]      rd_ptr_q;
	logic [owrs_pkg::QueueCntBits-1:0]      count_q;

	assign full = (count_q == owrs_pkg::QueueCntBits'(owrs_pkg::QueueDepth));
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- design/owrs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_back : search engine and result register
// Holds the ROM search state, runs one decoded operation per cycle while the
// result side is not stalled, and registers the result transaction.
// ----------------------------------------------------------------------------
module owrs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  owrs_pkg::op_entry_t head,
	output logic                pop,
	input  logic                result_stall,
	output logic                result_valid,
	output owrs_pkg::result_t   result
);

	logic [owrs_pkg::RomBits-1:0] rom_q, rom_d;
	logic [owrs_pkg::PosBits-1:0] last_disc_q, last_disc_d;
	logic                         last_dev_q, last_dev_d;
	logic [owrs_pkg::PosBits-1:0] bit_pos_q, bit_pos_d;
	logic [owrs_pkg::PosBits-1:0] last_zero_q, last_zero_d;
	logic                         in_pass_q, in_pass_d;
	logic                         out_valid_q;
	owrs_pkg::result_t            out_q, res;

	logic [owrs_pkg::IdxBits-1:0] idx;
	logic                         pos_ok;
	logic                         dir;
	logic [owrs_pkg::RomBits-1:0] rom_new;
	logic [owrs_pkg::PosBits-1:0] zero_new;
	logic                         dev_new;
	logic                         do_clear;

	assign pop = head_valid && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign result = out_q;

	assign idx = bit_pos_q[owrs_pkg::IdxBits-1:0] - 1'b1;
	assign pos_ok = (bit_pos_q != '0)
		&& (bit_pos_q <= owrs_pkg::PosBits'(owrs_pkg::RomBits));

	// branch choice for one bit slot
	always_comb begin
		unique case (head.pair)
			owrs_pkg::PAIR_FORCED: dir = head.id_bit;
			owrs_pkg::PAIR_CONFLICT: begin
				if (bit_pos_q < last_disc_q) dir = rom_q[idx];
				else dir = (bit_pos_q == last_disc_q);
			end
			default: dir = 1'b0;
		endcase
		rom_new = rom_q;
		rom_new[idx] = dir;
		zero_new = last_zero_q;
		if (head.pair == owrs_pkg::PAIR_CONFLICT && !dir) zero_new = bit_pos_q;
		dev_new = last_dev_q || (zero_new == '0);
	end

	always_comb begin
		res = '0;
		do_clear = 1'b0;
		rom_d = rom_q;
		last_disc_d = last_disc_q;
		last_dev_d = last_dev_q;
		bit_pos_d = bit_pos_q;
		last_zero_d = last_zero_q;
		in_pass_d = in_pass_q;
		unique case (head.op)
			owrs_pkg::OP_CLEAR: do_clear = 1'b1;
			owrs_pkg::OP_BEGIN: begin
				if (last_dev_q || !head.presence) begin
					do_clear = 1'b1;
					res.pass_done = 1'b1;
				end else begin
					in_pass_d = 1'b1;
					bit_pos_d = owrs_pkg::PosBits'(1);
					last_zero_d = '0;
					res.send_search_command = 1'b1;
				end
			end
			owrs_pkg::OP_PAIR: begin
				if (in_pass_q) begin
					if (head.pair == owrs_pkg::PAIR_ABORT || !pos_ok) begin
						do_clear = 1'b1;
						res.pass_done = 1'b1;
					end else begin
						rom_d = rom_new;
						last_zero_d = zero_new;
						res.write_valid = 1'b1;
						res.direction_bit = dir;
						bit_pos_d = bit_pos_q + 1'b1;
						if (bit_pos_q == owrs_pkg::PosBits'(owrs_pkg::RomBits)) begin
							res.pass_done = 1'b1;
							last_disc_d = zero_new;
							last_dev_d = dev_new;
							// a zero family code is not a real device
							if (rom_new[7:0] == 8'h00) begin
								do_clear = 1'b1;
							end else begin
								in_pass_d = 1'b0;
								bit_pos_d = owrs_pkg::PosBits'(1);
								res.found = 1'b1;
								res.address = rom_new;
								res.last_device = dev_new;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (do_clear) begin
			rom_d = '0;
			last_disc_d = '0;
			last_dev_d = 1'b0;
			bit_pos_d = owrs_pkg::PosBits'(1);
			last_zero_d = '0;
			in_pass_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q <= '0;
			last_disc_q <= '0;
			last_dev_q <= 1'b0;
			bit_pos_q <= owrs_pkg::PosBits'(1);
			last_zero_q <= '0;
			in_pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rom_q <= rom_d;
				last_disc_q <= last_disc_d;
				last_dev_q <= last_dev_d;
				bit_pos_q <= bit_pos_d;
				last_zero_q <= last_zero_d;
				in_pass_q <= in_pass_d;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_q <= res;
	end

endmodule

// ----- design/one_wire_rom_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_rom_search : 1-Wire ROM search engine
// Each transaction on the item channel gives exactly one transaction on the
// result channel. A new item is taken every cycle while the result side is
// not stalled; the rate is one item per clock, set by the search engine which
// runs one operation per cycle. A two-entry queue between the input decode
// and the engine absorbs result stalls, so item_stall rises only once two
// items are waiting behind a stalled result. Bus slot timing is up to the
// user: issue a begin after each bus reset, write the search command when
// asked, then one bit-pair item per search slot and write back direction_bit.
// ----------------------------------------------------------------------------
module one_wire_rom_search (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  owrs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output owrs_pkg::result_t result
);

	logic                queue_full;
	logic                push;
	owrs_pkg::op_entry_t push_entry;
	logic                pop;
	logic                head_valid;
	owrs_pkg::op_entry_t head;

	owrs_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.queue_full (queue_full),
		.item_stall (item_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	owrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	owrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- design/owrs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_checker : port-level checks for the ROM search engine
// Watches only the top-level ports; bound to every instance of the top.
// ----------------------------------------------------------------------------
module owrs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input owrs_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input owrs_pkg::result_t result
);

	// a fresh result needs a matching transaction taken on the item channel
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result appeared without a matching item");

	// input backs up only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stalled while result side empty");

	// an address is only reported on the final bit slot of a pass
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.pass_done && result.write_valid)
		else $error("found without end of pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.send_search_command |->
			!result.write_valid && !result.pass_done)
		else $error("search command mixed with other results");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |->
			result.address == '0 && !result.last_device)
		else $error("address driven without a found device");

endmodule

bind one_wire_rom_search owrs_checker u_owrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
